/* src/lmrs_pkg.sv */
// Shared types and constants for the LED matrix row scanner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lmrs_pkg;

  localparam int ROWS   = 8;
  localparam int PAGES  = 2;
  localparam int ROW_W  = 3;
  localparam int HOLD_W = 6;
  localparam int DIM_W  = 2;
  localparam int CNT_W  = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 2'd1;

  // Pin map: high nibble is the row pin, low nibble the column pin.
  // In each nibble bit 3 selects port two, bits 2..0 the pin number.
  localparam logic [7:0] PIN_MAP [ROWS] = '{
    8'hB7, 8'h03, 8'hA4, 8'h6C, 8'h18, 8'h9D, 8'h2B, 8'h5F
  };

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PAIR_FIRST  = 2'd0,
    PAIR_BOTH   = 2'd1,
    PAIR_SECOND = 2'd2,
    PAIR_NONE   = 2'd3
  } page_pair_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] fb_index;
    logic [7:0] fb_data;
    logic       scroll_on;
    logic [4:0] scroll_pos;
    logic       blink_off;
  } item_t;

  // Port register image: index 0 p1 dir, 1 p1 out, 2 p2 dir, 3 p2 out.
  typedef logic [3:0][7:0] ports_t;

  typedef struct packed {
    ports_t              ports;
    logic [HOLD_W-1:0]   hold;
  } row_drive_t;

endpackage

/* src/led_matrix_row_scanner.sv */
// LED matrix row scanner: one input register stage, then one result stage.
// Throughput: one request per cycle; while a result waits, a tick in the input register
// waits with it, and so does every request behind that tick.
// Reset (rst_n, synchronous): frame store, port registers, row and hold cleared,
// dim level set to one; no clearing pass, requests are taken at once.
`timescale 1ns / 1ps

module led_matrix_row_scanner
  import lmrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] fb_index, [11:4] fb_data, [12] scroll_on, [17:13] scroll_pos,
  // [18] blink_off, [23:19] zero
  input  logic [23:0] in_tdata,
  // [0] command
  input  logic        in_tuser,
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] port1_dir, [15:8] port1_out, [23:16] port2_dir, [31:24] port2_out,
  // [34:32] row_lit, [39:35] zero
  output logic [39:0] out_tdata,
  // Dim level register write.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DIM_W-1:0] cfg_data
);

  // Input register stage. The request waits here until the result stage can
  // take it; a write never needs the result register, so it never waits.
  item_t             s1_r;
  logic              s1_valid_r;
  logic              s1_go;
  logic              tick_go;

  // Scanner state. The port registers double as the result register: they
  // only change on a tick, and a tick only goes once the last result is taken.
  ports_t            ports_r;
  ports_t            ports_nxt;
  logic [ROW_W-1:0]  row_cnt_r;
  logic [ROW_W-1:0]  row_cnt_nxt;
  logic [HOLD_W-1:0] hold_r;
  logic [HOLD_W-1:0] hold_nxt;
  logic [DIM_W-1:0]  dim_r;
  logic              out_valid_r;

  logic [7:0]        page1_byte;
  logic [7:0]        page2_byte;
  row_drive_t        drive;

  assign s1_go   = s1_valid_r && (s1_r.cmd == CMD_WRITE || !out_valid_r || out_tready);
  assign tick_go = s1_go && s1_r.cmd == CMD_TICK;
  assign in_tready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r.cmd        <= cmd_t'(in_tuser);
      s1_r.fb_index   <= in_tdata[3:0];
      s1_r.fb_data    <= in_tdata[11:4];
      s1_r.scroll_on  <= in_tdata[12];
      s1_r.scroll_pos <= in_tdata[17:13];
      s1_r.blink_off  <= in_tdata[18];
    end
  end

  lmrs_frame_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (s1_go && s1_r.cmd == CMD_WRITE),
    .wr_index (s1_r.fb_index),
    .wr_data  (s1_r.fb_data),
    .rd_row   (row_cnt_r),
    .rd_page1 (page1_byte),
    .rd_page2 (page2_byte)
  );

  lmrs_row_decode u_decode (
    .row        (row_cnt_r),
    .page1_byte (page1_byte),
    .page2_byte (page2_byte),
    .scroll_on  (s1_r.scroll_on),
    .scroll_pos (s1_r.scroll_pos),
    .blink_off  (s1_r.blink_off),
    .dim_level  (dim_r),
    .drive      (drive)
  );

  // One refresh slot. While the on-time nibble runs the row stays lit; after
  // that all pins go off for the rest of the count, which is the blank time.
  // Only when the whole count is spent does the next row light up.
  always_comb begin
    ports_nxt   = ports_r;
    row_cnt_nxt = row_cnt_r;
    hold_nxt    = hold_r;
    if (hold_r[3:0] != 4'h0) begin
      hold_nxt = hold_r - 1'b1;
    end else if (hold_r != '0) begin
      ports_nxt = '0;
      hold_nxt  = hold_r - 1'b1;
    end else begin
      ports_nxt   = drive.ports;
      hold_nxt    = drive.hold;
      row_cnt_nxt = row_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_r     <= '0;
      row_cnt_r   <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
      dim_r       <= DIM_RESET;
    end else begin
      if (tick_go) begin
        ports_r   <= ports_nxt;
        row_cnt_r <= row_cnt_nxt;
        hold_r    <= hold_nxt;
      end
      if (tick_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        dim_r <= cfg_data;
      end
    end
  end

  // The row last lit is one behind the row counter.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, row_cnt_r - 1'b1, ports_r};

  // A write request leaves the scan state alone.
  a_write_keeps_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_r.cmd == CMD_WRITE && !tick_go |=> $stable(row_cnt_r) && $stable(hold_r))
    else $error("write request changed scan state");

  // During the on-time the lit row's pins do not move.
  a_on_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && hold_r[3:0] != 4'h0 |=> $stable(ports_r) && $stable(row_cnt_r))
    else $error("port registers changed during on-time");

  // The blank phase turns every pin off.
  a_blank_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && hold_r[3:0] == 4'h0 && hold_r != '0 |=> ports_r == '0)
    else $error("ports not cleared in blank phase");

  // A tick is never taken over a result that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !tick_go)
    else $error("tick overran a pending result");

  // An empty input register always takes a request.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input register empty but not ready");

endmodule

/* src/lmrs_frame_store.sv */
// Two-page frame store of the LED matrix row scanner, one byte per row.
// Depends on lmrs_pkg.
`timescale 1ns / 1ps

module lmrs_frame_store
  import lmrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [3:0]       wr_index,
  input  logic [7:0]       wr_data,
  input  logic [ROW_W-1:0] rd_row,
  output logic [7:0]       rd_page1,
  output logic [7:0]       rd_page2
);

  logic [7:0] page1_r [ROWS];
  logic [7:0] page2_r [ROWS];

  // Each page is its own bank, so both are read at the same row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        page1_r[i] <= '0;
        page2_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index[3]) begin
        page2_r[wr_index[ROW_W-1:0]] <= wr_data;
      end else begin
        page1_r[wr_index[ROW_W-1:0]] <= wr_data;
      end
    end
  end

  assign rd_page1 = page1_r[rd_row];
  assign rd_page2 = page2_r[rd_row];

endmodule

/* src/lmrs_row_decode.sv */
// Row decode of the LED matrix row scanner: scroll select, pin mapping,
// pixel count and on/blank time. Pure logic; depends on lmrs_pkg.
`timescale 1ns / 1ps

module lmrs_row_decode
  import lmrs_pkg::*;
(
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       page1_byte,
  input  logic [7:0]       page2_byte,
  input  logic             scroll_on,
  input  logic [4:0]       scroll_pos,
  input  logic             blink_off,
  input  logic [DIM_W-1:0] dim_level,
  output row_drive_t       drive
);

  logic [15:0]      window;
  logic [15:0]      shifted;
  logic [7:0]       pixels;
  logic [7:0]       col1;
  logic [7:0]       col2;
  logic [CNT_W-1:0] count;
  logic [3:0]       row_pin;
  logic [7:0]       row_mask;
  page_pair_t       pair;

  assign pair = page_pair_t'(scroll_pos[4:3]);

  // The scrolled byte is the upper half of {hi, lo} shifted left.
  always_comb begin
    unique case (pair)
      PAIR_FIRST:  window = {8'h00, page1_byte};
      PAIR_BOTH:   window = {page1_byte, page2_byte};
      PAIR_SECOND: window = {page2_byte, 8'h00};
      PAIR_NONE:   window = 16'h0000;
      default:     window = 16'h0000;
    endcase
  end

  assign shifted = window << scroll_pos[2:0];
  assign pixels  = scroll_on ? shifted[15:8] : page1_byte;

  always_comb begin
    col1  = '0;
    col2  = '0;
    count = '0;
    for (int k = 0; k < ROWS; k++) begin
      if (pixels[ROWS-1-k]) begin
        if (PIN_MAP[k][3]) begin
          col2[PIN_MAP[k][2:0]] = 1'b1;
        end else begin
          col1[PIN_MAP[k][2:0]] = 1'b1;
        end
        count = count + 1'b1;
      end
    end
  end

  assign row_pin  = PIN_MAP[row][7:4];
  assign row_mask = 8'h01 << row_pin[2:0];

  always_comb begin
    logic [7:0] c1;
    logic [7:0] c2;
    c1 = blink_off ? 8'h00 : col1;
    c2 = blink_off ? 8'h00 : col2;
    drive.ports[0] = c1  | (row_pin[3] ? 8'h00 : row_mask);
    drive.ports[1] = ~c1 | (row_pin[3] ? 8'h00 : row_mask);
    drive.ports[2] = c2  | (row_pin[3] ? row_mask : 8'h00);
    drive.ports[3] = ~c2 | (row_pin[3] ? row_mask : 8'h00);
    if (count == '0) begin
      drive.hold = '0;
    end else begin
      drive.hold = {dim_level, 4'b0000} | {1'b0, count, 1'b0};
    end
  end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the LED matrix row scanner: writes frame store bytes,
// runs scan ticks and compares every port image against an in-bench scan predictor.
// Depends on lmrs_pkg and led_matrix_row_scanner from src.
`timescale 1ns / 1ps

module tb;
  import lmrs_pkg::*;

  // A phase may see long stretches of receiver stall, but never this many idle cycles.
  localparam int STALL_LIMIT = 2000;

  // Pin map as the board is wired: high nibble row pin, low nibble column pin,
  // bit 3 of a nibble picks port two.
  localparam logic [7:0] WIRING [8] = '{
    8'hB7, 8'h03, 8'hA4, 8'h6C, 8'h18, 8'h9D, 8'h2B, 8'h5F
  };

  // One port image as the block reports it after a tick.
  typedef struct {
    logic [7:0] p1_dir;
    logic [7:0] p1_out;
    logic [7:0] p2_dir;
    logic [7:0] p2_out;
    logic [2:0] row;
  } scan_out_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  // Requests waiting to be driven, and the port images still owed by the block.
  item_t     pending_reqs[$];
  scan_out_t expected_scans[$];
  item_t     cur_req;

  // Shadow of the scanner state.
  logic [7:0] fb_mem [16];
  logic [2:0] row_ctr;
  logic [5:0] hold_ctr;
  logic [7:0] p1_dir_q, p1_out_q, p2_dir_q, p2_out_q;
  logic [1:0] dim_lvl;

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;
  scan_out_t want_scan;
  scan_out_t got_scan;
  scan_out_t new_scan;

  led_matrix_row_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Pixel byte for row r. In scrolled view the two page bytes are treated as one
  // 16-bit window and the upper byte after the shift is what gets shown.
  function automatic logic [7:0] row_pixels(logic [2:0] r, logic scroll_on,
                                            logic [4:0] pos);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] window;
    hi = '0;
    lo = '0;
    if (!scroll_on) return fb_mem[{1'b0, r}];
    case (page_pair_t'(pos[4:3]))
      PAIR_FIRST: begin
        lo = fb_mem[{1'b0, r}];
      end
      PAIR_BOTH: begin
        hi = fb_mem[{1'b0, r}];
        lo = fb_mem[{1'b1, r}];
      end
      PAIR_SECOND: begin
        hi = fb_mem[{1'b1, r}];
      end
      default: begin
      end
    endcase
    window = {hi, lo} << pos[2:0];
    return window[15:8];
  endfunction

  // Light the row under row_ctr: columns from the pixel byte through the pin map,
  // the row pin always driven high, on-time from the pixel count.
  function automatic void light_row(logic scroll_on, logic [4:0] pos, logic blink);
    logic [7:0] pix;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [3:0] pin;
    int         lit;
    pix = row_pixels(row_ctr, scroll_on, pos);
    c1 = '0;
    c2 = '0;
    lit = 0;
    for (int k = 0; k < 8; k++) begin
      if (pix[7 - k]) begin
        pin = WIRING[k][3:0];
        if (pin[3]) c2[pin[2:0]] = 1'b1;
        else c1[pin[2:0]] = 1'b1;
        lit++;
      end
    end
    // Blink hides the columns but keeps the on-time the pixels earned.
    hold_ctr = (lit == 0) ? 6'd0 : 6'(((lit << 1) | (int'(dim_lvl) << 4)) & 'h3f);
    if (blink) begin
      c1 = '0;
      c2 = '0;
    end
    p1_dir_q = c1;
    p1_out_q = ~c1;
    p2_dir_q = c2;
    p2_out_q = ~c2;
    pin = WIRING[row_ctr][7:4];
    if (pin[3]) begin
      p2_dir_q[pin[2:0]] = 1'b1;
      p2_out_q[pin[2:0]] = 1'b1;
    end else begin
      p1_dir_q[pin[2:0]] = 1'b1;
      p1_out_q[pin[2:0]] = 1'b1;
    end
    row_ctr = row_ctr + 3'd1;
  endfunction

  // Apply one request to the shadow state; returns 1 with the port image for a tick.
  function automatic bit scan_step(input item_t rq, output scan_out_t res);
    res = '{default: '0};
    if (rq.cmd == CMD_WRITE) begin
      fb_mem[rq.fb_index] = rq.fb_data;
      return 1'b0;
    end
    if (hold_ctr[3:0] != 4'd0) begin
      // On-time still running: ports stay as they are.
      hold_ctr = hold_ctr - 6'd1;
    end else begin
      p1_dir_q = '0;
      p1_out_q = '0;
      p2_dir_q = '0;
      p2_out_q = '0;
      if (hold_ctr != 6'd0) hold_ctr = hold_ctr - 6'd1;
      else light_row(rq.scroll_on, rq.scroll_pos, rq.blink_off);
    end
    res.p1_dir = p1_dir_q;
    res.p1_out = p1_out_q;
    res.p2_dir = p2_dir_q;
    res.p2_out = p2_out_q;
    res.row    = row_ctr - 3'd1;
    return 1'b1;
  endfunction

  // Driver: feeds requests from the pending queue and runs the predictor on
  // every request the block accepts. A dim level write is mirrored when it lands.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      foreach (fb_mem[i]) fb_mem[i] = '0;
      row_ctr  = '0;
      hold_ctr = '0;
      p1_dir_q = '0;
      p1_out_q = '0;
      p2_dir_q = '0;
      p2_out_q = '0;
      dim_lvl  = DIM_RESET;
    end else begin
      if (cfg_valid && cfg_ready) dim_lvl = cfg_data;
      if (in_tvalid && in_tready) begin
        if (scan_step(cur_req, new_scan)) expected_scans.push_back(new_scan);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'd0, cur_req.blink_off, cur_req.scroll_pos, cur_req.scroll_on,
                        cur_req.fb_data, cur_req.fb_index};
          in_tuser  <= cur_req.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: every accepted port image is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_scan.p1_dir = out_tdata[7:0];
        got_scan.p1_out = out_tdata[15:8];
        got_scan.p2_dir = out_tdata[23:16];
        got_scan.p2_out = out_tdata[31:24];
        got_scan.row    = out_tdata[34:32];
        if (expected_scans.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want_scan = expected_scans.pop_front();
          check_field("port1_dir", want_scan.p1_dir, got_scan.p1_dir);
          check_field("port1_out", want_scan.p1_out, got_scan.p1_out);
          check_field("port2_dir", want_scan.p2_dir, got_scan.p2_dir);
          check_field("port2_out", want_scan.p2_out, got_scan.p2_out);
          check_field("row_lit", 8'(want_scan.row), 8'(got_scan.row));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run that accepts nothing for too long is a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic item_t make_req(cmd_t cmd, logic [3:0] idx, logic [7:0] data,
                                     logic scroll_on, logic [4:0] pos, logic blink);
    item_t rq;
    rq.cmd        = cmd;
    rq.fb_index   = idx;
    rq.fb_data    = data;
    rq.scroll_on  = scroll_on;
    rq.scroll_pos = pos;
    rq.blink_off  = blink;
    return rq;
  endfunction

  // Random request: mostly ticks, and half the written bytes are blank so that
  // empty rows let the scan move on quickly.
  function automatic item_t random_req();
    return make_req(($urandom_range(9) < 3) ? CMD_WRITE : CMD_TICK,
                    4'($urandom_range(15)),
                    ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255)),
                    1'($urandom_range(1)), 5'($urandom_range(31)),
                    ($urandom_range(4) == 0));
  endfunction

  // Wait until every request is in and every result is out, then let the block
  // settle before the next dim level write.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_scans.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dim(logic [1:0] level);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  localparam logic [7:0] FB_PATTERN [16] = '{
    8'hFF, 8'h01, 8'h80, 8'h00, 8'hA5, 8'h5A, 8'h0F, 8'hF0,
    8'h3C, 8'hC3, 8'h7E, 8'h81, 8'hFF, 8'h00, 8'h55, 8'hAA
  };
  // Dim level and idle split per random phase: sender-light/receiver-heavy,
  // then the reverse, then two phases with no idling at all.
  localparam logic [1:0] PHASE_DIM  [4] = '{2'd0, 2'd3, 2'd2, 2'd0};
  localparam int         PHASE_SEND [4] = '{17, 79, 0, 0};
  localparam int         PHASE_RECV [4] = '{79, 17, 0, 0};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset dim level: fill both pages, then scan.
    send_idle_pct <= 17;
    recv_idle_pct <= 79;
    for (int i = 0; i < 16; i++) begin
      pending_reqs.push_back(make_req(CMD_WRITE, 4'(i), FB_PATTERN[i], 1'($urandom_range(1)),
                                      5'($urandom_range(31)), 1'($urandom_range(1))));
    end
    // Row 0 is a full row: lit with blink, then blanked on the very next tick.
    pending_reqs.push_back(make_req(CMD_TICK, 4'hF, 8'hFF, 1'b0, 5'h00, 1'b1));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h0, 8'h00, 1'b1, 5'h1F, 1'b0));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h5, 8'h5A, 1'b1, 5'h18, 1'b0));
    pending_reqs.push_back(make_req(CMD_TICK, 4'hA, 8'hA5, 1'b1, 5'h07, 1'b0));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h0, 8'h00, 1'b1, 5'h08, 1'b1));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h0, 8'h00, 1'b1, 5'h0F, 1'b0));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h0, 8'h00, 1'b1, 5'h10, 1'b0));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h0, 8'h00, 1'b1, 5'h17, 1'b0));
    pending_reqs.push_back(make_req(CMD_TICK, 4'h0, 8'h00, 1'b0, 5'h1F, 1'b1));
    wait_idle();

    // Random phases, each split in two bursts with a full drain in between so the
    // sender also pauses until every result has come back.
    for (int ph = 0; ph < 4; ph++) begin
      write_dim(PHASE_DIM[ph]);
      send_idle_pct <= PHASE_SEND[ph];
      recv_idle_pct <= PHASE_RECV[ph];
      for (int burst = 0; burst < 2; burst++) begin
        for (int n = 0; n < 120; n++) pending_reqs.push_back(random_req());
        wait_idle();
      end
    end

    if (mismatches == 0 && expected_scans.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
